// ----- src/mcqsb_pkg.sv -----
// Shared types and constants for the multi-channel queue/stack buffer.
// Used by the top level; no dependencies.
package mcqsb_pkg;

   // Default sizing handed to the top level parameters
   localparam int CHANNELS_DEF   = 16;
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Field widths of one request beat and one response beat
   localparam int KIND_W      = 2;
   localparam int CHANNEL_W   = 4;
   localparam int PUSH_W      = 32;
   localparam int READ_W      = 32;
   localparam int FILL_W      = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   // Register file
   localparam int                CSR_ADDR_W     = 3;
   localparam int                CSR_DATA_W     = 32;
   localparam int                MODE_W         = 16;
   localparam logic              REG_STACK_MODE = 1'b0;
   localparam logic [MODE_W-1:0] MODE_RESET     = 16'd10;

   // Status carried alongside the store read
   typedef struct packed {
      logic              ok;
      logic              has_read;
      logic [FILL_W-1:0] fill;
   } stat_type;

endpackage

// ----- src/multi_channel_queue_stack_buffer.sv -----
// Multi-channel queue/stack buffer: a request beat passes through stage one (store read and
// status) and then the response register; throughput one beat per cycle while the response
// is not stalled; the single store port and the per-channel pointer update at the accept edge set that figure.
// Reset (synchronous, active high) zeroes every head, tail and count and loads the
// stack mode mask with 10; the word store is not cleared.
// Depends on mcqsb_pkg and mcqsb_store.
module multi_channel_queue_stack_buffer #(
   parameter int CHANNELS   = mcqsb_pkg::CHANNELS_DEF,
   parameter int DEPTH      = mcqsb_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = mcqsb_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: kind [1:0], channel [5:2], push_data [37:6], zero [39:38]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mcqsb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // response: ok [0], read_data [32:1], fill_level [37:33], zero [39:38]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mcqsb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mcqsb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mcqsb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mcqsb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   import mcqsb_pkg::*;

   localparam int PW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW  = (CHANNELS * DEPTH > 2) ? $clog2(CHANNELS * DEPTH) : 1;

   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   // Unpack the request beat
   logic [KIND_W-1:0]    kind;
   logic [CHANNEL_W-1:0] chan;
   logic [PUSH_W-1:0]    push_data;
   assign kind      = req_tdata[KIND_W-1:0];
   assign chan      = req_tdata[KIND_W +: CHANNEL_W];
   assign push_data = req_tdata[KIND_W + CHANNEL_W +: PUSH_W];

   // Register port
   logic [MODE_W-1:0] mode_ff;
   logic              csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_STACK_MODE)) begin
         mode_ff <= csr_pwdata[MODE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_STACK_MODE) begin
         csr_prdata = CSR_DATA_W'(mode_ff);
      end
   end

   // Per-channel pointer state
   logic [PW-1:0] head_ff  [CHANNELS];
   logic [PW-1:0] tail_ff  [CHANNELS];
   logic [CW-1:0] count_ff [CHANNELS];

   // Pipeline handshake
   logic     s1_valid_ff;
   stat_type s1_stat_ff;
   logic     rsp_valid_ff;
   logic     s1_go;
   logic     accept;
   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // Decode the operation against the addressed channel
   logic [CIW-1:0] ch_idx;
   logic           ch_ok;
   logic           stk;
   logic [PW-1:0]  hd, tl, tl_prev, hd_next, tl_next;
   logic [CW-1:0]  cnt;
   logic [PW-1:0]  head_in, tail_in;
   logic [CW-1:0]  count_in;
   logic           upd;
   logic           wr_en;
   logic [PW-1:0]  rd_ptr;
   stat_type       stat_in;
   logic [AW-1:0]  base;

   assign ch_idx  = CIW'(chan);
   assign ch_ok   = (32'(chan) < CHANNELS);
   assign stk     = mode_ff[chan];
   assign hd      = head_ff[ch_idx];
   assign tl      = tail_ff[ch_idx];
   assign cnt     = count_ff[ch_idx];
   assign hd_next = (hd == PTR_LAST) ? '0 : hd + PW'(1);
   assign tl_next = (tl == PTR_LAST) ? '0 : tl + PW'(1);
   assign tl_prev = (tl == '0) ? PTR_LAST : tl - PW'(1);
   assign base    = AW'(ch_idx) * AW'(DEPTH);

   always_comb begin
      head_in  = hd;
      tail_in  = tl;
      count_in = cnt;
      upd      = 1'b0;
      wr_en    = 1'b0;
      rd_ptr   = stk ? tl_prev : hd;
      stat_in  = '0;
      case (kind)
         KIND_PUSH: begin
            if (cnt != CNT_FULL) begin
               wr_en      = 1'b1;
               upd        = 1'b1;
               tail_in    = tl_next;
               count_in   = cnt + CW'(1);
               stat_in.ok = 1'b1;
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (cnt != '0) begin
               stat_in.ok       = 1'b1;
               stat_in.has_read = 1'b1;
               if (kind == KIND_POP) begin
                  upd      = 1'b1;
                  count_in = cnt - CW'(1);
                  if (stk) begin
                     tail_in = tl_prev;
                  end else begin
                     head_in = hd_next;
                  end
               end
            end
         end
         KIND_CLEAR: begin
            upd        = 1'b1;
            head_in    = '0;
            tail_in    = '0;
            count_in   = '0;
            stat_in.ok = 1'b1;
         end
         default: begin
            upd = 1'b0;
         end
      endcase
      if (!ch_ok) begin
         stat_in = '0;
         upd     = 1'b0;
         wr_en   = 1'b0;
      end
      stat_in.fill = ch_ok ? FILL_W'(count_in) : '0;
   end

   // Advance the channel pointers on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (accept && upd) begin
         head_ff[ch_idx]  <= head_in;
         tail_ff[ch_idx]  <= tail_in;
         count_ff[ch_idx] <= count_in;
      end
   end

   // Shared word store
   logic [DATA_WIDTH-1:0] rd_word;

   mcqsb_store #(
      .ADDR_W (AW),
      .DATA_W (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (base + AW'(tl)),
      .wr_data (DATA_WIDTH'(push_data)),
      .rd_en   (accept),
      .rd_addr (base + AW'(rd_ptr)),
      .rd_data (rd_word)
   );

   // Stage one: status waits beside the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= stat_in;
      end
   end

   // Response register
   logic [READ_W-1:0] rsp_data_ff;
   logic              rsp_ok_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_valid_ff) begin
         rsp_ok_ff   <= s1_stat_ff.ok;
         rsp_fill_ff <= s1_stat_ff.fill;
         rsp_data_ff <= s1_stat_ff.has_read ? READ_W'(rd_word) : '0;
      end
   end

   // Pack the response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 1 - READ_W - FILL_W){1'b0}},
                        rsp_fill_ff, rsp_data_ff, rsp_ok_ff};

endmodule

// ----- src/mcqsb_store.sv -----
// Word store shared by all channels: one write port, one registered read port.
// Generic; no package dependencies.
module mcqsb_store #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write the pushed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
